### rtl/iqf_pkg.sv
// iqf_pkg: shared types, constants and a float helper for the iq sample converter
// no dependencies
`timescale 1ns / 1ps
package iqf_pkg;
   localparam int unsigned RING_DEPTH = 65536;
   localparam logic [16:0] INDEX_MAX = 17'h1FFFF;
   localparam int unsigned QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      FMT_CU8  = 2'd0,
      FMT_CS8  = 2'd1,
      FMT_CS16 = 2'd2,
      FMT_BAD  = 2'd3
   } format_type;

   typedef enum logic [2:0] {
      REG_FORMAT = 3'd0,
      REG_MASK   = 3'd1,
      REG_COUNT  = 3'd2,
      REG_SRC    = 3'd3,
      REG_DST    = 3'd4,
      REG_SCALE  = 3'd5
   } reg_index_type;

   // classified work item between front and back
   typedef struct packed {
      logic        is_unsigned;
      logic        is_wide;
      logic [15:0] i_code;
      logic [15:0] q_code;
      logic [15:0] ring_slot;
      logic        window_last;
      logic        setup_error;
   } work_type;

   // exact float of a signed 16-bit integer times 2^-exp_shift
   function automatic logic [31:0] int_to_float(input logic signed [15:0] v,
                                                input logic [7:0] exp_shift);
      logic [15:0] mag;
      logic [4:0]  lead;
      logic [22:0] frac;
      logic [31:0] r;
      mag  = v[15] ? 16'(-v) : 16'(v);
      lead = 5'd0;
      for (int k = 0; k < 16; k++) begin
         if (mag[k]) lead = 5'(k);
      end
      frac = 23'(({7'd0, mag} << (5'd23 - lead)));
      if (mag == 16'd0) r = 32'd0;
      else r = {v[15], 8'(8'd127 + {3'd0, lead} - exp_shift), frac};
      return r;
   endfunction
endpackage

### rtl/iqf_front.sv
// iqf_front: config registers, sample index, checks and field pick
// depends on iqf_pkg
`timescale 1ns / 1ps
module iqf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_data,
   input  logic                 item_valid,
   input  logic [31:0]          source_word,
   input  logic                 window_start,
   output iqf_pkg::work_type    work,
   output logic [31:0]          scale_bits
);
   logic [1:0]  format_ff;
   logic [15:0] mask_ff;
   logic [16:0] count_ff;
   logic [31:0] src_ff, dst_ff, scale_ff;
   logic [16:0] index_ff, index_in, idx;
   logic [16:0] capacity;
   logic [32:0] src_end;
   logic        err, shift;
   logic [15:0] half;
   logic [31:0] slot_sum;

   assign csr_ready  = 1'b1;
   assign scale_bits = scale_ff;
   assign idx        = window_start ? 17'd0 : index_ff;
   assign capacity   = {1'b0, mask_ff} + 17'd1;
   assign src_end    = {1'b0, src_ff} + {16'd0, count_ff};
   assign slot_sum   = dst_ff + {15'd0, idx};

   always_comb begin
      err = 1'b0;
      if ((capacity & {1'b0, mask_ff}) != 17'd0) err = 1'b1;
      if ({15'd0, capacity} > iqf_pkg::RING_DEPTH) err = 1'b1;
      if (count_ff > capacity) err = 1'b1;
      if (src_end[32]) err = 1'b1;
      if (idx >= count_ff) err = 1'b1;
      if (format_ff == iqf_pkg::FMT_BAD) err = 1'b1;
   end

   assign shift = src_ff[0] ^ idx[0];
   assign half  = shift ? source_word[31:16] : source_word[15:0];

   always_comb begin
      work = '0;
      work.setup_error = err;
      work.is_unsigned = (format_ff == iqf_pkg::FMT_CU8);
      work.is_wide     = (format_ff == iqf_pkg::FMT_CS16);
      if (format_ff == iqf_pkg::FMT_CS16) begin
         work.i_code = source_word[15:0];
         work.q_code = source_word[31:16];
      end else begin
         work.i_code = {8'd0, half[7:0]};
         work.q_code = {8'd0, half[15:8]};
      end
      if (!err) begin
         work.ring_slot   = slot_sum[15:0] & mask_ff;
         work.window_last = (idx + 17'd1 == count_ff);
      end
   end

   assign index_in = (idx < iqf_pkg::INDEX_MAX) ? idx + 17'd1 : iqf_pkg::INDEX_MAX;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= 2'd0;
         mask_ff   <= 16'hFFFF;
         count_ff  <= 17'd0;
         src_ff    <= 32'd0;
         dst_ff    <= 32'd0;
         scale_ff  <= 32'd1006665857;
         index_ff  <= 17'd0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               iqf_pkg::REG_FORMAT: format_ff <= csr_data[1:0];
               iqf_pkg::REG_MASK:   mask_ff   <= csr_data[15:0];
               iqf_pkg::REG_COUNT:  count_ff  <= csr_data[16:0];
               iqf_pkg::REG_SRC:    src_ff    <= csr_data;
               iqf_pkg::REG_DST:    dst_ff    <= csr_data;
               iqf_pkg::REG_SCALE:  scale_ff  <= csr_data;
               default: ;
            endcase
         end
         if (item_valid) index_ff <= index_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      item_valid && window_start |=> index_ff == 17'd1)
      else $error("index not restarted");
   assert property (@(posedge clock) disable iff (reset)
      work.setup_error |-> work.ring_slot == 16'd0 && !work.window_last)
      else $error("error item carries data");
   assert property (@(posedge clock) disable iff (reset)
      item_valid && !window_start && index_ff != iqf_pkg::INDEX_MAX
      |=> index_ff == $past(index_ff) + 17'd1)
      else $error("index did not advance");
endmodule

### rtl/iqf_queue.sv
// iqf_queue: small fifo of classified work between front and back
// depends on iqf_pkg
`timescale 1ns / 1ps
module iqf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  iqf_pkg::work_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output iqf_pkg::work_type pop_data
);
   localparam int unsigned AW = $clog2(iqf_pkg::QUEUE_DEPTH);
   iqf_pkg::work_type store_ff [iqf_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   fill_ff;
   logic do_push, do_pop;

   assign full     = (fill_ff == (AW+1)'(iqf_pkg::QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) store_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
         fill_ff <= fill_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (AW+1)'(iqf_pkg::QUEUE_DEPTH))
      else $error("queue overfilled");
   assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("fill count wrong");
   assert property (@(posedge clock) disable iff (reset)
      ((wr_ff - rd_ff) == fill_ff[AW-1:0]))
      else $error("pointers disagree with fill");
endmodule

### rtl/iqf_back.sv
// iqf_back: two stage float conversion of one queued beat, output register
// depends on iqf_pkg
`timescale 1ns / 1ps
module iqf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  iqf_pkg::work_type in_work,
   input  logic [31:0]       scale_bits,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [15:0]       ring_slot,
   output logic [31:0]       in_phase_bits,
   output logic [31:0]       quadrature_bits,
   output logic              window_last,
   output logic              setup_error
);
   // stage a: products for cu8, exact values for signed formats
   logic        a_valid_ff;
   iqf_pkg::work_type a_work_ff;
   logic [31:0] a_i_ff, a_q_ff;
   logic        a_i_neg_ff, a_q_neg_ff;
   logic [33:0] a_i_prod_ff, a_q_prod_ff;
   logic [7:0]  a_exp_ff;
   logic        a_sign_ff, a_zero_ff, a_special_ff;
   logic [31:0] a_special_bits_ff;
   logic        o_valid_ff;
   logic [15:0] o_slot_ff;
   logic [31:0] o_i_ff, o_q_ff;
   logic        o_last_ff, o_err_ff;
   logic        adv_a, adv_o;

   logic [7:0]  s_exp;
   logic [23:0] s_man;
   logic        s_zero;
   logic [9:0]  i_diff, q_diff;
   logic [8:0]  i_mag, q_mag;
   logic [31:0] i_exact, q_exact;

   assign s_exp  = scale_bits[30:23];
   assign s_zero = (s_exp == 8'd0);
   assign s_man  = {1'b1, scale_bits[22:0]};
   // twice (code - 127.5): 2*code - 255
   assign i_diff = {1'b0, in_work.i_code[7:0], 1'b0} - 10'd255;
   assign q_diff = {1'b0, in_work.q_code[7:0], 1'b0} - 10'd255;
   assign i_mag  = i_diff[9] ? 9'(-i_diff) : i_diff[8:0];
   assign q_mag  = q_diff[9] ? 9'(-q_diff) : q_diff[8:0];

   always_comb begin
      if (in_work.is_wide) begin
         i_exact = iqf_pkg::int_to_float(in_work.i_code, 8'd15);
         q_exact = iqf_pkg::int_to_float(in_work.q_code, 8'd15);
      end else begin
         i_exact = iqf_pkg::int_to_float(16'($signed(in_work.i_code[7:0])), 8'd7);
         q_exact = iqf_pkg::int_to_float(16'($signed(in_work.q_code[7:0])), 8'd7);
      end
   end

   assign adv_o    = !o_valid_ff || out_ready;
   assign adv_a    = !a_valid_ff || adv_o;
   assign in_ready = adv_a;

   always_ff @(posedge clock) begin
      if (adv_a) begin
         a_work_ff    <= in_work;
         a_i_ff       <= i_exact;
         a_q_ff       <= q_exact;
         a_i_neg_ff   <= i_diff[9];
         a_q_neg_ff   <= q_diff[9];
         a_i_prod_ff  <= {10'd0, s_man} * {25'd0, i_mag};
         a_q_prod_ff  <= {10'd0, s_man} * {25'd0, q_mag};
         a_exp_ff     <= s_exp;
         a_sign_ff    <= scale_bits[31];
         a_zero_ff    <= s_zero;
         a_special_ff <= (s_exp == 8'hFF);
         a_special_bits_ff <= scale_bits;
      end
   end

   // normalize and round a cu8 product (value = prod * 2^(exp-127-23-1))
   function automatic logic [31:0] round_prod(input logic [33:0] prod, input logic neg,
                                              input logic sgn, input logic [7:0] e,
                                              input logic zero, input logic special,
                                              input logic [31:0] sbits);
      logic [5:0]  lead;
      logic [33:0] norm;
      logic [22:0] frac;
      logic        g, st, up;
      logic [24:0] m;
      logic signed [10:0] ex;
      logic        rs;
      logic        min_up;
      logic [31:0] r;
      rs = sgn ^ neg;
      lead = 6'd0;
      for (int k = 0; k < 34; k++) begin
         if (prod[k]) lead = 6'(k);
      end
      norm = prod << (6'd33 - lead);
      frac = norm[32:10];
      g    = norm[9];
      st   = |norm[8:0];
      up   = g && (st || frac[0]);
      m    = {2'b01, frac} + 25'(up);
      ex   = 11'($signed({3'd0, e})) - 11'sd24 + 11'($signed({5'd0, lead}));
      // just below the smallest normal: subnormal rounding may reach it
      min_up = (ex == 11'sd0) && (&norm[32:10]);
      if (m[24]) ex = ex + 11'sd1;
      if (special) begin
         if (sbits[22:0] != 23'd0) r = sbits | 32'h0040_0000;
         else r = {rs, 8'hFF, 23'd0};
      end else if (zero) r = {rs, 31'd0};
      else if (ex >= 11'sd255) r = {rs, 8'hFF, 23'd0};
      else if (min_up) r = {rs, 8'd1, 23'd0};
      else if (ex <= 11'sd0) r = {rs, 31'd0};
      else r = {rs, 8'(ex), m[24] ? m[23:1] : m[22:0]};
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (adv_o && a_valid_ff) begin
         if (a_work_ff.setup_error) begin
            o_i_ff <= 32'd0;
            o_q_ff <= 32'd0;
         end else if (a_work_ff.is_unsigned) begin
            o_i_ff <= round_prod(a_i_prod_ff, a_i_neg_ff, a_sign_ff, a_exp_ff, a_zero_ff,
                                 a_special_ff, a_special_bits_ff);
            o_q_ff <= round_prod(a_q_prod_ff, a_q_neg_ff, a_sign_ff, a_exp_ff, a_zero_ff,
                                 a_special_ff, a_special_bits_ff);
         end else begin
            o_i_ff <= a_i_ff;
            o_q_ff <= a_q_ff;
         end
         o_slot_ff <= a_work_ff.ring_slot;
         o_last_ff <= a_work_ff.window_last;
         o_err_ff  <= a_work_ff.setup_error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (adv_a) a_valid_ff <= in_valid;
         if (adv_o) o_valid_ff <= a_valid_ff;
      end
   end

   assign out_valid       = o_valid_ff;
   assign ring_slot       = o_slot_ff;
   assign in_phase_bits   = o_i_ff;
   assign quadrature_bits = o_q_ff;
   assign window_last     = o_last_ff;
   assign setup_error     = o_err_ff;

   assert property (@(posedge clock) disable iff (reset)
      o_valid_ff && !out_ready |=> o_valid_ff && $stable(o_i_ff))
      else $error("held result changed");
   assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !adv_o |=> a_valid_ff)
      else $error("stage a dropped beat");
   assert property (@(posedge clock) disable iff (reset)
      o_valid_ff && o_err_ff |-> o_i_ff == 32'd0 && o_q_ff == 32'd0)
      else $error("error beat has data");
endmodule

### rtl/iq_sample_to_float_convert.sv
// iq_sample_to_float_convert: top level of the iq sample to float32 converter
// depends on iqf_pkg, iqf_front, iqf_queue, iqf_back
//
// usage: push one 32-bit source word per sample on req_ while req_full is low;
// req_window_start restarts the sample index. results come out oldest first on
// rsp_ while rsp_empty is low and leave on rsp_pop. registers are to be written
// by the user on the csr_ channel (always ready) only while the block is idle;
// the block itself does not enforce it. a pushed beat passes the queue write,
// the product stage and the rounding stage into the output register.
// throughput: one beat per cycle while the receiver keeps up, set by the
// combinational front checks and the two-stage back pipeline.
// a stalled receiver holds the output register; the back stops, the 4-entry
// queue fills and req_full rises, with nothing dropped.
// reset puts the config registers to their defaults and clears the sample index and the queue.
`timescale 1ns / 1ps
module iq_sample_to_float_convert (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_source_word,
   input  logic        req_window_start,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [15:0] rsp_ring_slot,
   output logic [31:0] rsp_in_phase_bits,
   output logic [31:0] rsp_quadrature_bits,
   output logic        rsp_window_last,
   output logic        rsp_setup_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   iqf_pkg::work_type front_work, queue_work;
   logic [31:0] scale_bits;
   logic accept, q_empty, back_ready, out_valid;

   assign accept = req_push && !req_full;

   iqf_front u_front (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .item_valid(accept), .source_word(req_source_word),
      .window_start(req_window_start),
      .work(front_work), .scale_bits(scale_bits)
   );

   iqf_queue u_queue (
      .clock(clock), .reset(reset),
      .push(accept), .push_data(front_work), .full(req_full),
      .pop(back_ready), .empty(q_empty), .pop_data(queue_work)
   );

   iqf_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(!q_empty), .in_ready(back_ready), .in_work(queue_work),
      .scale_bits(scale_bits),
      .out_valid(out_valid), .out_ready(rsp_pop),
      .ring_slot(rsp_ring_slot), .in_phase_bits(rsp_in_phase_bits),
      .quadrature_bits(rsp_quadrature_bits), .window_last(rsp_window_last),
      .setup_error(rsp_setup_error)
   );

   assign rsp_empty = !out_valid;
endmodule
